// File: rtl/ipv4_rxcs_pkg.sv
package ipv4_rxcs_pkg;

	localparam int OFFSET_BITS = 16;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
	localparam logic [15:0] MIN_HDR = 16'd20;

	typedef enum logic [2:0] {
		RSN_OK       = 3'd0,
		RSN_SHORT    = 3'd1,
		RSN_VERSION  = 3'd2,
		RSN_HDR_LEN  = 3'd3,
		RSN_TOT_LEN  = 3'd4,
		RSN_FRAGMENT = 3'd5
	} reason_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	typedef struct packed {
		logic        sum_ok;
		logic [15:0] transport_sum;
		reason_t     reject_reason;
		logic [5:0]  header_length;
		logic [15:0] total_length;
	} result_t;

	function automatic logic [15:0] add_folded(input logic [15:0] acc, input logic [15:0] v);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, v};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// File: rtl/ipv4_rxcs_in_reg.sv
module ipv4_rxcs_in_reg
	import ipv4_rxcs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  beat_t in_beat,
	output logic  in_stall,
	input  logic  take,
	output logic  s1_valid,
	output beat_t s1_beat
);

	logic  valid_s1;
	beat_t beat_s1;

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_beat;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_beat  = beat_s1;

endmodule

// File: rtl/ipv4_rxcs_core.sv
module ipv4_rxcs_core
	import ipv4_rxcs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s1_valid,
	input  beat_t   s1_beat,
	output logic    take,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t result
);

	logic [OFFSET_BITS-1:0] byte_offset_q;
	logic [5:0]             hdr_len_q;
	logic [15:0]            ip_len_q;
	logic                   version_bad_q;
	logic                   fragment_q;
	logic [15:0]            sum_q;

	logic                   out_valid_q;
	result_t                result_q;

	logic                   out_free;
	logic [15:0]            off16;
	logic [OFFSET_BITS-1:0] n;
	logic [15:0]            n16;
	logic [5:0]             hdr_len_d;
	logic [15:0]            ip_len_d;
	logic                   version_bad_d;
	logic                   fragment_d;
	logic [15:0]            sum_d;
	logic [15:0]            word;
	logic                   in_range;
	reason_t                reason;
	result_t                result_d;

	assign out_free = !out_valid_q || !out_stall;
	assign take     = s1_valid && out_free;
	assign off16    = 16'(byte_offset_q);

	always_comb begin
		hdr_len_d     = hdr_len_q;
		ip_len_d      = ip_len_q;
		version_bad_d = version_bad_q;
		fragment_d    = fragment_q;
		unique case (off16)
			16'd0: begin
				version_bad_d = (s1_beat.data_byte[7:4] != 4'd4);
				hdr_len_d     = {s1_beat.data_byte[3:0], 2'b00};
			end
			16'd2: ip_len_d = {s1_beat.data_byte, ip_len_q[7:0]};
			16'd3: ip_len_d = {ip_len_q[15:8], s1_beat.data_byte};
			16'd6: if (s1_beat.data_byte[5:0] != 6'd0) fragment_d = 1'b1;
			16'd7: if (s1_beat.data_byte != 8'd0) fragment_d = 1'b1;
			default: ;
		endcase
	end

	// header bytes lie below offset 20, so the pre-update length fields are safe here
	assign in_range = (off16 >= MIN_HDR) && (off16 >= {10'd0, hdr_len_q}) && (off16 < ip_len_q);
	assign word     = byte_offset_q[0] ? {8'd0, s1_beat.data_byte} : {s1_beat.data_byte, 8'd0};
	assign sum_d    = in_range ? add_folded(sum_q, word) : sum_q;

	assign n   = (byte_offset_q != OFFSET_MAX) ? byte_offset_q + 1'b1 : OFFSET_MAX;
	assign n16 = 16'(n);

	always_comb begin
		priority if (n16 < MIN_HDR) begin
			reason = RSN_SHORT;
		end else if (version_bad_d) begin
			reason = RSN_VERSION;
		end else if ({10'd0, hdr_len_d} < MIN_HDR || {10'd0, hdr_len_d} > n16) begin
			reason = RSN_HDR_LEN;
		end else if (ip_len_d < {10'd0, hdr_len_d} || ip_len_d > n16) begin
			reason = RSN_TOT_LEN;
		end else if (fragment_d) begin
			reason = RSN_FRAGMENT;
		end else begin
			reason = RSN_OK;
		end
	end

	always_comb begin
		result_d.sum_ok        = (reason == RSN_OK);
		result_d.transport_sum = (reason == RSN_OK) ? sum_d : 16'd0;
		result_d.reject_reason = reason;
		result_d.header_length = hdr_len_d;
		result_d.total_length  = ip_len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			hdr_len_q     <= '0;
			ip_len_q      <= '0;
			version_bad_q <= 1'b0;
			fragment_q    <= 1'b0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				if (s1_beat.last_byte) begin
					byte_offset_q <= '0;
					hdr_len_q     <= '0;
					ip_len_q      <= '0;
					version_bad_q <= 1'b0;
					fragment_q    <= 1'b0;
					sum_q         <= '0;
				end else begin
					byte_offset_q <= n;
					hdr_len_q     <= hdr_len_d;
					ip_len_q      <= ip_len_d;
					version_bad_q <= version_bad_d;
					fragment_q    <= fragment_d;
					sum_q         <= sum_d;
				end
			end
			if (out_free) begin
				out_valid_q <= take && s1_beat.last_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && s1_beat.last_byte) begin
			result_q <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && s1_beat.last_byte |=> byte_offset_q == '0 && sum_q == 16'd0)
		else $error("frame state not cleared after last beat");

	a_ok_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> result_q.sum_ok == (result_q.reject_reason == RSN_OK))
		else $error("sum_ok disagrees with reject_reason");

	a_reject_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.sum_ok |-> result_q.transport_sum == 16'd0)
		else $error("rejected frame carries a nonzero sum");

	a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !take)
		else $error("beat consumed while result is blocked");

endmodule

// File: rtl/ipv4_rx_transport_checksum_unit.sv
// The last byte of a frame waits in the input register until the core takes it;
// the verdict is loaded into the result register as that byte is taken.
// Throughput: one byte per cycle while the result is not stalled; one input register
// and one result register separate the byte stream from the result channel.
// A stalled result blocks input once the input register is full.
// Reset (arst_n low) clears all frame state and drops both valid registers.
module ipv4_rx_transport_checksum_unit
	import ipv4_rxcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sum_ok,
	output logic [15:0] transport_sum,
	output logic [2:0]  reject_reason,
	output logic [5:0]  header_length,
	output logic [15:0] total_length
);

	beat_t   in_beat;
	beat_t   s1_beat;
	logic    s1_valid;
	logic    take;
	result_t result;

	assign in_beat.data_byte = data_byte;
	assign in_beat.last_byte = last_byte;

	ipv4_rxcs_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_beat  (in_beat),
		.in_stall (in_stall),
		.take     (take),
		.s1_valid (s1_valid),
		.s1_beat  (s1_beat)
	);

	ipv4_rxcs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_beat   (s1_beat),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign sum_ok        = result.sum_ok;
	assign transport_sum = result.transport_sum;
	assign reject_reason = result.reject_reason;
	assign header_length = result.header_length;
	assign total_length  = result.total_length;

endmodule

// File: verif/ipv4_rx_transport_checksum_unit_tb.sv
`timescale 1ns / 1ps

module ipv4_rx_transport_checksum_unit_tb;
	import ipv4_rxcs_pkg::*;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        sum_ok;
	logic [15:0] transport_sum;
	logic [2:0]  reject_reason;
	logic [5:0]  header_length;
	logic [15:0] total_length;

	ipv4_rx_transport_checksum_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sum_ok        (sum_ok),
		.transport_sum (transport_sum),
		.reject_reason (reject_reason),
		.header_length (header_length),
		.total_length  (total_length)
	);

	// frame parser mirror
	logic [15:0] rx_offset;
	logic [5:0]  rx_hdr_len;
	logic [15:0] rx_ip_len;
	logic        rx_ver_bad;
	logic        rx_frag;
	logic [15:0] rx_sum;

	result_t     pending_verdicts[$];
	logic [7:0]  frame_buf[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int errors = 0;
	int frames_sent = 0;
	int bytes_sent = 0;
	int verdicts_checked = 0;
	int rejects_seen = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Result-side stall; a long hold-off counts down here.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic clear_frame_state();
		rx_offset = '0;
		rx_hdr_len = '0;
		rx_ip_len = '0;
		rx_ver_bad = 1'b0;
		rx_frag = 1'b0;
		rx_sum = '0;
	endtask

	task automatic predict_checksum(input logic [7:0] b, input logic lst);
		logic [15:0] off;
		logic [15:0] n;
		logic [15:0] word;
		logic [16:0] s;
		logic [15:0] hl;
		reason_t     why;
		result_t     r;
		off = rx_offset;
		case (off)
			16'd0: begin
				rx_ver_bad = (b[7:4] != 4'd4);
				rx_hdr_len = {b[3:0], 2'b00};
			end
			16'd2: rx_ip_len[15:8] = b;
			16'd3: rx_ip_len[7:0] = b;
			16'd6: if (b[5:0] != 6'd0) rx_frag = 1'b1;
			16'd7: if (b != 8'd0) rx_frag = 1'b1;
			default: ;
		endcase
		hl = {10'd0, rx_hdr_len};
		if (off >= MIN_HDR && off >= hl && off < rx_ip_len) begin
			// even offset is the high byte of the word
			word = off[0] ? {8'h00, b} : {b, 8'h00};
			s = {1'b0, rx_sum} + {1'b0, word};
			rx_sum = s[15:0] + {15'd0, s[16]};
		end
		n = (off < OFFSET_MAX) ? off + 16'd1 : OFFSET_MAX;
		rx_offset = n;
		if (lst) begin
			if (n < MIN_HDR)
				why = RSN_SHORT;
			else if (rx_ver_bad)
				why = RSN_VERSION;
			else if (hl < MIN_HDR || hl > n)
				why = RSN_HDR_LEN;
			else if (rx_ip_len < hl || rx_ip_len > n)
				why = RSN_TOT_LEN;
			else if (rx_frag)
				why = RSN_FRAGMENT;
			else
				why = RSN_OK;
			r.sum_ok = (why == RSN_OK);
			r.transport_sum = (why == RSN_OK) ? rx_sum : 16'd0;
			r.reject_reason = why;
			r.header_length = rx_hdr_len;
			r.total_length = rx_ip_len;
			pending_verdicts.push_back(r);
			clear_frame_state();
		end
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual sum %0h reason %0d",
					$time, transport_sum, reject_reason);
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_checked++;
				if (want.reject_reason != RSN_OK)
					rejects_seen++;
				check_field("sum_ok", 16'(want.sum_ok), 16'(sum_ok));
				check_field("transport_sum", want.transport_sum, transport_sum);
				check_field("reject_reason", 16'(want.reject_reason), 16'(reject_reason));
				check_field("header_length", 16'(want.header_length), 16'(header_length));
				check_field("total_length", want.total_length, total_length);
			end
		end
	end

	// One beat; valid and payload hold until the block takes it.
	task automatic send_beat(input logic [7:0] b, input logic lst);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_checksum(b, lst);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_buf.size(); i++)
			send_beat(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	task automatic make_frame(input logic [3:0] ver, input logic [3:0] ihl,
			input logic [15:0] tl, input logic [7:0] flags_hi, input logic [7:0] frag_lo,
			input int len);
		int i;
		logic [7:0] rnd;
		frame_buf.delete();
		for (i = 0; i < len; i++) begin
			rnd = 8'($urandom_range(0, 255));
			case (i)
				0: frame_buf.push_back({ver, ihl});
				2: frame_buf.push_back(tl[15:8]);
				3: frame_buf.push_back(tl[7:0]);
				6: frame_buf.push_back(flags_hi);
				7: frame_buf.push_back(frag_lo);
				default: frame_buf.push_back(rnd);
			endcase
		end
	endtask

	// Mostly well-formed frames with random content, some broken, a few pure noise.
	task automatic make_random_frame();
		int pick;
		int hl;
		int tl;
		int len;
		logic [3:0] ver;
		logic [3:0] ihl;
		logic [7:0] f6;
		logic [7:0] f7;
		pick = $urandom_range(0, 99);
		ver = 4'd4;
		ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
		hl = ihl * 4;
		tl = hl + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 120) :
			$urandom_range(0, 40));
		len = tl + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0);
		f6 = 8'($urandom_range(0, 255)) & 8'hc0;
		f7 = 8'h00;
		if (pick < 80) begin
		end else if (pick < 84) begin
			ver = 4'($urandom_range(5, 19) % 16);
		end else if (pick < 87) begin
			ihl = 4'($urandom_range(0, 4));
		end else if (pick < 90) begin
			tl = $urandom_range(0, hl - 1);
		end else if (pick < 93) begin
			len = $urandom_range(1, len - 1);
		end else if (pick < 96) begin
			if ($urandom_range(0, 1))
				f6 = f6 | 8'($urandom_range(1, 63));
			else
				f7 = 8'($urandom_range(1, 255));
		end else begin
			ver = 4'($urandom_range(0, 15));
			ihl = 4'($urandom_range(0, 15));
			tl = $urandom_range(0, 80);
			f6 = 8'($urandom_range(0, 255));
			f7 = 8'($urandom_range(0, 255));
			len = $urandom_range(1, 80);
		end
		make_frame(ver, ihl, tl[15:0], f6, f7, len);
	endtask

	task automatic test_good_frames();
		int i;
		idle_pct = 0;
		stall_pct = 0;
		make_frame(4'd4, 4'd5, 16'd20, 8'h00, 8'h00, 20);
		send_frame();
		make_frame(4'd4, 4'd5, 16'd21, 8'h00, 8'h00, 21);
		send_frame();
		make_frame(4'd4, 4'd5, 16'd27, 8'h00, 8'h00, 27);
		send_frame();
		// link padding past total length, DF and reserved bit set
		make_frame(4'd4, 4'd5, 16'd30, 8'hc0, 8'h00, 40);
		send_frame();
		// options are never summed
		make_frame(4'd4, 4'd15, 16'd64, 8'h40, 8'h00, 64);
		send_frame();
		// all-ones payload forces end-around carries
		make_frame(4'd4, 4'd5, 16'd61, 8'h00, 8'h00, 61);
		for (i = 20; i < 61; i++)
			frame_buf[i] = 8'hff;
		send_frame();
	endtask

	task automatic test_reject_reasons();
		idle_pct = 0;
		stall_pct = 0;
		make_frame(4'd4, 4'd5, 16'd20, 8'h00, 8'h00, 1);
		send_frame();
		make_frame(4'd4, 4'd5, 16'h1234, 8'h00, 8'h00, 3);
		send_frame();
		make_frame(4'd4, 4'd5, 16'd20, 8'h00, 8'h00, 19);
		send_frame();
		make_frame(4'd6, 4'd5, 16'd20, 8'h00, 8'h00, 20);
		send_frame();
		make_frame(4'd6, 4'd4, 16'd40, 8'h00, 8'h00, 40);
		send_frame();
		make_frame(4'd4, 4'd4, 16'd40, 8'h00, 8'h00, 40);
		send_frame();
		make_frame(4'd4, 4'd0, 16'd20, 8'h00, 8'h00, 20);
		send_frame();
		make_frame(4'd4, 4'd15, 16'd40, 8'h00, 8'h00, 40);
		send_frame();
		make_frame(4'd4, 4'd5, 16'd10, 8'h00, 8'h00, 30);
		send_frame();
		make_frame(4'd4, 4'd5, 16'd100, 8'h00, 8'h00, 50);
		send_frame();
		make_frame(4'd4, 4'd5, 16'hffff, 8'h00, 8'h00, 30);
		send_frame();
		// more-fragments, offset high bits, offset low bits
		make_frame(4'd4, 4'd5, 16'd40, 8'h20, 8'h00, 40);
		send_frame();
		make_frame(4'd4, 4'd5, 16'd40, 8'h1f, 8'h00, 40);
		send_frame();
		make_frame(4'd4, 4'd5, 16'd40, 8'h00, 8'h01, 40);
		send_frame();
		make_frame(4'd4, 4'd5, 16'd40, 8'h00, 8'h80, 40);
		send_frame();
	endtask

	// Runs past the saturation point of the byte counter.
	task automatic test_long_frame();
		idle_pct = 0;
		stall_pct = 0;
		make_frame(4'd4, 4'd5, 16'hffff, 8'h00, 8'h00, 65540);
		send_frame();
		make_frame(4'd4, 4'd5, 16'hfff0, 8'h40, 8'h00, 65535);
		send_frame();
	endtask

	task automatic test_backpressure();
		int i;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 400;
		for (i = 0; i < 10; i++) begin
			make_frame(4'd4, 4'd5, 16'd24, 8'h00, 8'h00, 24);
			send_frame();
		end
	endtask

	task automatic test_random_traffic();
		int phase;
		int start_bytes;
		int start_frames;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 48; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 48; end
				default: begin idle_pct = 17; stall_pct = 17; end
			endcase
			start_bytes = bytes_sent;
			start_frames = frames_sent;
			while (bytes_sent - start_bytes < 375 || frames_sent - start_frames < 12) begin
				make_random_frame();
				send_frame();
			end
		end
	endtask

	initial begin
		clear_frame_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_good_frames();
		test_reject_reasons();
		test_long_frame();
		test_backpressure();
		test_random_traffic();

		in_valid <= 1'b0;
		stall_pct = 0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("Sent %0d frames, %0d bytes: header checks, a saturating long frame,",
			frames_sent, bytes_sent);
		$display("a held-off output and four idle mixes; %0d verdicts checked, %0d rejects",
			verdicts_checked, rejects_seen);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
